/* design/asa_pkg.sv */
// shared types and constants of the atlas shelf allocator
// no dependencies; used by atlas_shelf_allocator
`timescale 1ns / 1ps

package asa_pkg;

  localparam int PAGE_WIDTH  = 256;
  localparam int PAGE_HEIGHT = 256;
  localparam int ROUND_STEP  = 4;
  localparam int MAX_PAGES   = 16;

  localparam int NUM_CLASSES = PAGE_HEIGHT / ROUND_STEP + 1;
  localparam int CLS_W       = $clog2(NUM_CLASSES);
  localparam int PAGE_AW     = $clog2(MAX_PAGES);
  localparam int PCNT_W      = $clog2(MAX_PAGES + 1);

  // field widths fixed by the word format
  localparam int CMD_W  = 1;
  localparam int RECT_W = 16;
  localparam int PID_W  = 4;
  localparam int CRD_W  = 9;
  localparam int GEN_W  = 16;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [RECT_W-1:0] rect_width;
    logic [RECT_W-1:0] rect_height;
  } in_word_t;

  typedef struct packed {
    logic [PID_W-1:0] page_id;
    logic [CRD_W-1:0] pos_x;
    logic [CRD_W-1:0] pos_y;
    logic             full_res;
    logic [GEN_W-1:0] generation;
  } out_word_t;

  typedef struct packed {
    logic [PID_W-1:0] page;
    logic [CRD_W-1:0] free_width;
    logic [CRD_W-1:0] y;
  } shelf_ent_t;

  localparam int SHELF_W = $bits(shelf_ent_t);

endpackage

/* design/asa_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module asa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/atlas_shelf_allocator.sv */
// atlas shelf allocator top level: sequencer around shelf and page rams
// depends on asa_pkg and asa_ram
`timescale 1ns / 1ps
//
//  channel | dir | payload     | handshake
//  --------+-----+-------------+--------------------------
//  in      | in  | in_word_t   | in_valid / in_stall
//  out     | out | out_word_t  | out_valid / out_stall
//
//  a clear word goes through S_CLR, an allocate that fits its open shelf through S_SHELF;
//  one that opens a shelf goes on through S_SCAN (skipped while no page is open) and S_DECIDE: the page
//  table ram is scanned one page per cycle, newest page first, through its single read port
//  one word is in work at a time; in_stall is high from acceptance until the
//  result has been loaded into the output register
//  a held output register (out_stall) holds the sequencer in its last state
//  rst_n is synchronous; valid bits, page count and generation reset to zero,
//  ram contents need no clearing

module atlas_shelf_allocator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  asa_pkg::in_word_t in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output asa_pkg::out_word_t out_word
);

  import asa_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SHELF  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_CLR    = 3'd4;

  logic [2:0]             state_r, state_nxt;
  logic [CLS_W-1:0]       cls_r, cls_nxt;
  logic [CRD_W-1:0]       sh_r, sh_nxt;
  logic [CRD_W-1:0]       w_r, w_nxt;
  logic [NUM_CLASSES-1:0] valid_r, valid_nxt;
  logic [PCNT_W-1:0]      page_count_r, page_count_nxt;
  logic [GEN_W-1:0]       gen_r, gen_nxt;
  logic [PAGE_AW-1:0]     scan_idx_r, scan_idx_nxt;
  logic                   found_r, found_nxt;
  logic [PAGE_AW-1:0]     best_r, best_nxt;
  logic [CRD_W-1:0]       best_h_r, best_h_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_word_t              out_word_r, out_word_nxt;

  // ram ports
  logic                   shelf_we;
  logic [CLS_W-1:0]       shelf_raddr;
  shelf_ent_t             shelf_wdata;
  logic [SHELF_W-1:0]     shelf_rbits;
  shelf_ent_t             shelf_rd;
  logic                   page_we;
  logic [PAGE_AW-1:0]     page_waddr;
  logic [PAGE_AW-1:0]     page_raddr;
  logic [CRD_W-1:0]       page_wdata;
  logic [CRD_W-1:0]       page_rd;

  // input decode: round height up, clamp height and width to page, pick the class
  logic [RECT_W:0]        h_up;
  logic [CRD_W-1:0]       sh_clamp;
  logic [CLS_W-1:0]       cls_in;
  logic [CRD_W-1:0]       sh_in;
  logic [CRD_W-1:0]       w_in;

  logic                   in_acc;
  logic                   out_free;
  logic                   need_shelf;
  logic [PAGE_AW-1:0]     new_pg;
  logic [CRD_W-1:0]       new_h;
  logic [CRD_W-1:0]       hit_free;

  assign h_up     = {1'b0, in_word.rect_height} + (RECT_W + 1)'(ROUND_STEP - 1);
  assign sh_clamp = (h_up > (RECT_W + 1)'(PAGE_HEIGHT)) ? CRD_W'(PAGE_HEIGHT)
                                                        : CRD_W'(h_up);
  assign cls_in   = CLS_W'(sh_clamp / ROUND_STEP);
  assign sh_in    = CRD_W'((sh_clamp / ROUND_STEP) * ROUND_STEP);
  assign w_in     = (in_word.rect_width > RECT_W'(PAGE_WIDTH)) ? CRD_W'(PAGE_WIDTH)
                                                               : CRD_W'(in_word.rect_width);

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // shelf table: class -> page, free width, y
  assign shelf_raddr = (state_r == S_IDLE) ? cls_in : cls_r;
  assign shelf_rd    = shelf_ent_t'(shelf_rbits);

  asa_ram #(
    .WIDTH (SHELF_W),
    .DEPTH (NUM_CLASSES)
  ) u_shelf_ram (
    .clk   (clk),
    .we    (shelf_we),
    .waddr (cls_r),
    .wdata (shelf_wdata),
    .raddr (shelf_raddr),
    .rdata (shelf_rbits)
  );

  // page table: free height per open page
  always_comb begin
    case (state_r)
      S_SHELF: page_raddr = PAGE_AW'(page_count_r - PCNT_W'(1));
      S_SCAN:  page_raddr = scan_idx_r - PAGE_AW'(1);
      default: page_raddr = '0;
    endcase
  end

  asa_ram #(
    .WIDTH (CRD_W),
    .DEPTH (MAX_PAGES)
  ) u_page_ram (
    .clk   (clk),
    .we    (page_we),
    .waddr (page_waddr),
    .wdata (page_wdata),
    .raddr (page_raddr),
    .rdata (page_rd)
  );

  // open shelf still fits, or a new one must be cut
  assign need_shelf = !valid_r[cls_r] || (shelf_rd.free_width < w_r);
  assign hit_free   = shelf_rd.free_width - w_r;
  // new shelf goes to the best page, or to a freshly opened page
  assign new_pg     = found_r ? best_r : PAGE_AW'(page_count_r);
  assign new_h      = (found_r ? best_h_r : CRD_W'(PAGE_HEIGHT)) - sh_r;

  always_comb begin
    state_nxt      = state_r;
    cls_nxt        = cls_r;
    sh_nxt         = sh_r;
    w_nxt          = w_r;
    valid_nxt      = valid_r;
    page_count_nxt = page_count_r;
    gen_nxt        = gen_r;
    scan_idx_nxt   = scan_idx_r;
    found_nxt      = found_r;
    best_nxt       = best_r;
    best_h_nxt     = best_h_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_word_nxt   = out_word_r;
    shelf_we       = 1'b0;
    shelf_wdata    = shelf_rd;
    page_we        = 1'b0;
    page_waddr     = new_pg;
    page_wdata     = new_h;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cls_nxt = cls_in;
          sh_nxt  = sh_in;
          w_nxt   = w_in;
          state_nxt = (in_word.cmd == CMD_CLEAR) ? S_CLR : S_SHELF;
        end
      end

      S_SHELF: begin
        if (need_shelf) begin
          found_nxt = 1'b0;
          if (page_count_r == '0) begin
            state_nxt = S_DECIDE;
          end else begin
            // newest page first
            scan_idx_nxt = PAGE_AW'(page_count_r - PCNT_W'(1));
            state_nxt    = S_SCAN;
          end
        end else if (out_free) begin
          shelf_we               = 1'b1;
          shelf_wdata.free_width = hit_free;
          out_valid_nxt          = 1'b1;
          out_word_nxt.page_id    = shelf_rd.page;
          out_word_nxt.pos_x      = hit_free;
          out_word_nxt.pos_y      = shelf_rd.y;
          out_word_nxt.full_res   = 1'b0;
          out_word_nxt.generation = gen_r;
          state_nxt = S_IDLE;
        end
      end

      S_SCAN: begin
        // strictly smaller free height wins, so ties stay with the newer page
        if ((page_rd >= sh_r) && (!found_r || (best_h_r > page_rd))) begin
          found_nxt  = 1'b1;
          best_nxt   = scan_idx_r;
          best_h_nxt = page_rd;
        end
        if (scan_idx_r == '0) begin
          state_nxt = S_DECIDE;
        end else begin
          scan_idx_nxt = scan_idx_r - PAGE_AW'(1);
        end
      end

      S_DECIDE: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_word_nxt.generation = gen_r;
          state_nxt               = S_IDLE;
          if (!found_r && (page_count_r >= PCNT_W'(MAX_PAGES))) begin
            // no page left: refuse, state untouched
            out_word_nxt.page_id  = '0;
            out_word_nxt.pos_x    = '0;
            out_word_nxt.pos_y    = '0;
            out_word_nxt.full_res = 1'b1;
          end else begin
            page_we = 1'b1;
            if (!found_r) begin
              page_count_nxt = page_count_r + PCNT_W'(1);
            end
            valid_nxt[cls_r]       = 1'b1;
            shelf_we               = 1'b1;
            shelf_wdata.page       = new_pg;
            shelf_wdata.free_width = CRD_W'(PAGE_WIDTH) - w_r;
            shelf_wdata.y          = new_h;
            out_word_nxt.page_id   = new_pg;
            out_word_nxt.pos_x     = CRD_W'(PAGE_WIDTH) - w_r;
            out_word_nxt.pos_y     = new_h;
            out_word_nxt.full_res  = 1'b0;
          end
        end
      end

      S_CLR: begin
        if (out_free) begin
          valid_nxt      = '0;
          page_count_nxt = '0;
          gen_nxt        = gen_r + GEN_W'(1);
          out_valid_nxt  = 1'b1;
          out_word_nxt.page_id    = '0;
          out_word_nxt.pos_x      = '0;
          out_word_nxt.pos_y      = '0;
          out_word_nxt.full_res   = 1'b0;
          out_word_nxt.generation = gen_r + GEN_W'(1);
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      page_count_r <= '0;
      gen_r        <= '0;
      out_valid_r  <= 1'b0;
      found_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      page_count_r <= page_count_nxt;
      gen_r        <= gen_nxt;
      out_valid_r  <= out_valid_nxt;
      found_r      <= found_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    cls_r      <= cls_nxt;
    sh_r       <= sh_nxt;
    w_r        <= w_nxt;
    scan_idx_r <= scan_idx_nxt;
    best_r     <= best_nxt;
    best_h_r   <= best_h_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule
